@@ rtl/ets_pkg.sv @@
// Shared constants, types and rank function of the escape target selector.
`default_nettype none
package ets_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int COORD_BITS     = 24;
   localparam int ID_BITS        = 16;
   localparam int SCORE_BITS     = 32;
   localparam int TOL_BITS       = 23;
   localparam int IDX_BITS       = $clog2(MAX_CANDIDATES);
   localparam int COUNT_BITS     = $clog2(MAX_CANDIDATES + 1);
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int SQ_BITS        = 2 * TOL_BITS;
   localparam int SUM_BITS       = SQ_BITS + 1;

   typedef logic [1:0] op_type;
   localparam op_type OP_START  = 2'd0;
   localparam op_type OP_CAND   = 2'd1;
   localparam op_type OP_FINISH = 2'd2;

   typedef logic [1:0] reason_type;
   localparam reason_type REASON_OWNER    = 2'd0;
   localparam reason_type REASON_ENTRY    = 2'd1;
   localparam reason_type REASON_AT_ENTRY = 2'd2;

   localparam logic PLAN_RETREAT   = 1'b0;
   localparam logic PLAN_EXHAUSTED = 1'b1;

   localparam logic [TOL_BITS-1:0]   TOL_RESET  = TOL_BITS'(2048);
   localparam logic [SCORE_BITS-1:0] SCORE_FLIP = {1'b1, {(SCORE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                         start;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
   } dist_req_type;

   typedef struct packed {
      logic done;
      logic far;
   } dist_rsp_type;

   function automatic logic ranks_above(input logic [SCORE_BITS-1:0] ka,
                                        input logic [ID_BITS-1:0]    ia,
                                        input logic [SCORE_BITS-1:0] kb,
                                        input logic [ID_BITS-1:0]    ib);
      if (ka != kb) begin
         return ka > kb;
      end
      return ia < ib;
   endfunction

endpackage
`default_nettype wire

@@ rtl/escape_target_selector_top.sv @@
// Escape target selector: candidate intake, near-store scan and decision sequencer.
//
// A start item (op 0) leaves busy low. A candidate item (op 1) holds busy
// while the distance test runs: it stops early when the owner is clearly
// outside the tolerance box, else it walks squares of dx, dy and the tolerance
// through one shared multiplier. A finish item (op 2) holds busy while it
// scans the N near candidates stored (one store read and one rank compare per
// entry), then for the entry distance test when no far candidate was found.
// Its decision appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, and must be taken then: there is no back-pressure. A start or a
// candidate item gives no result, nor does op 3. The user must write the
// tolerance register through csr_ while the block is idle; it is not enforced.
`default_nettype none
module escape_target_selector_top
   import ets_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_op,
   input  wire logic signed [COORD_BITS-1:0] req_pose_x,
   input  wire logic signed [COORD_BITS-1:0] req_pose_y,
   input  wire logic signed [COORD_BITS-1:0] req_entry_x,
   input  wire logic signed [COORD_BITS-1:0] req_entry_y,
   input  wire logic signed [SCORE_BITS-1:0] req_cand_score,
   input  wire logic [ID_BITS-1:0]           req_cand_id,
   input  wire logic signed [COORD_BITS-1:0] req_owner_x,
   input  wire logic signed [COORD_BITS-1:0] req_owner_y,
   output logic                              rsp_valid,
   output logic                              rsp_plan_kind,
   output logic [1:0]                        rsp_reason_code,
   output logic signed [COORD_BITS-1:0]      rsp_target_x,
   output logic signed [COORD_BITS-1:0]      rsp_target_y,
   output logic                              rsp_retired_valid,
   output logic [ID_BITS-1:0]                rsp_spent_id,
   output logic                              rsp_store_overflow,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [TOL_BITS-1:0]          csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CAND     = 6'b000010,
      ST_SCAN_RD  = 6'b000100,
      ST_SCAN_CMP = 6'b001000,
      ST_DECIDE   = 6'b010000,
      ST_ENTRY    = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [TOL_BITS-1:0]          tol_ff, tol_in;
   logic signed [COORD_BITS-1:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic signed [COORD_BITS-1:0] entry_x_ff, entry_x_in, entry_y_ff, entry_y_in;
   logic [SCORE_BITS-1:0]        cand_key_ff, cand_key_in;
   logic [ID_BITS-1:0]           cand_id_ff, cand_id_in;
   logic signed [COORD_BITS-1:0] cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic [COUNT_BITS-1:0]        near_count_ff, near_count_in;
   logic                         far_found_ff, far_found_in;
   logic [SCORE_BITS-1:0]        far_key_ff, far_key_in;
   logic [ID_BITS-1:0]           far_id_ff, far_id_in;
   logic signed [COORD_BITS-1:0] far_x_ff, far_x_in, far_y_ff, far_y_in;
   logic                         overflow_ff, overflow_in;
   logic [COUNT_BITS-1:0]        scan_idx_ff, scan_idx_in;
   logic                         worst_found_ff, worst_found_in;
   logic [SCORE_BITS-1:0]        worst_key_ff, worst_key_in;
   logic [ID_BITS-1:0]           worst_id_ff, worst_id_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   reason_type                   rsp_reason_ff, rsp_reason_in;
   logic signed [COORD_BITS-1:0] rsp_tx_ff, rsp_tx_in, rsp_ty_ff, rsp_ty_in;
   logic                         rsp_rvalid_ff, rsp_rvalid_in;
   logic [ID_BITS-1:0]           rsp_rid_ff, rsp_rid_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   dist_req_type                 dist_req;
   dist_rsp_type                 dist_rsp;
   logic                         accept;
   logic                         wr_en, rd_en;
   logic [SCORE_BITS-1:0]        rd_key;
   logic [ID_BITS-1:0]           rd_id;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   ets_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .dist_req (dist_req),
      .robot_x  (robot_x_ff),
      .robot_y  (robot_y_ff),
      .tol      (tol_ff),
      .dist_rsp (dist_rsp)
   );

   ets_near_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (near_count_ff[IDX_BITS-1:0]),
      .wr_key  (cand_key_ff),
      .wr_id   (cand_id_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[IDX_BITS-1:0]),
      .rd_key  (rd_key),
      .rd_id   (rd_id)
   );

   always_comb begin
      state_in       = state_ff;
      tol_in         = tol_ff;
      robot_x_in     = robot_x_ff;
      robot_y_in     = robot_y_ff;
      entry_x_in     = entry_x_ff;
      entry_y_in     = entry_y_ff;
      cand_key_in    = cand_key_ff;
      cand_id_in     = cand_id_ff;
      cand_x_in      = cand_x_ff;
      cand_y_in      = cand_y_ff;
      near_count_in  = near_count_ff;
      far_found_in   = far_found_ff;
      far_key_in     = far_key_ff;
      far_id_in      = far_id_ff;
      far_x_in       = far_x_ff;
      far_y_in       = far_y_ff;
      overflow_in    = overflow_ff;
      scan_idx_in    = scan_idx_ff;
      worst_found_in = worst_found_ff;
      worst_key_in   = worst_key_ff;
      worst_id_in    = worst_id_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_reason_in  = rsp_reason_ff;
      rsp_tx_in      = rsp_tx_ff;
      rsp_ty_in      = rsp_ty_ff;
      rsp_rvalid_in  = rsp_rvalid_ff;
      rsp_rid_in     = rsp_rid_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      dist_req.start = 1'b0;
      dist_req.px    = req_owner_x;
      dist_req.py    = req_owner_y;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      if (csr_valid && csr_ready) begin
         tol_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_START: begin
                     robot_x_in    = req_pose_x;
                     robot_y_in    = req_pose_y;
                     entry_x_in    = req_entry_x;
                     entry_y_in    = req_entry_y;
                     near_count_in = '0;
                     far_found_in  = 1'b0;
                     far_key_in    = '0;
                     far_id_in     = '0;
                     far_x_in      = '0;
                     far_y_in      = '0;
                     overflow_in   = 1'b0;
                  end
                  OP_CAND: begin
                     cand_key_in    = SCORE_BITS'(req_cand_score) ^ SCORE_FLIP;
                     cand_id_in     = req_cand_id;
                     cand_x_in      = req_owner_x;
                     cand_y_in      = req_owner_y;
                     dist_req.start = 1'b1;
                     state_in       = ST_CAND;
                  end
                  OP_FINISH: begin
                     scan_idx_in    = '0;
                     worst_found_in = 1'b0;
                     worst_key_in   = '0;
                     worst_id_in    = '0;
                     state_in       = ST_SCAN_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_CAND: begin
            if (dist_rsp.done) begin
               if (dist_rsp.far) begin
                  if (!far_found_ff ||
                      ranks_above(cand_key_ff, cand_id_ff, far_key_ff, far_id_ff)) begin
                     far_found_in = 1'b1;
                     far_key_in   = cand_key_ff;
                     far_id_in    = cand_id_ff;
                     far_x_in     = cand_x_ff;
                     far_y_in     = cand_y_ff;
                  end
               end else if (near_count_ff < COUNT_BITS'(MAX_CANDIDATES)) begin
                  wr_en         = 1'b1;
                  near_count_in = near_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            if (scan_idx_ff == near_count_ff) begin
               state_in = ST_DECIDE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (!far_found_ff || ranks_above(rd_key, rd_id, far_key_ff, far_id_ff)) begin
               if (!worst_found_ff ||
                   ranks_above(worst_key_ff, worst_id_ff, rd_key, rd_id)) begin
                  worst_found_in = 1'b1;
                  worst_key_in   = rd_key;
                  worst_id_in    = rd_id;
               end
            end
            scan_idx_in = scan_idx_ff + 1'b1;
            state_in    = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            if (far_found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = PLAN_RETREAT;
               rsp_reason_in = REASON_OWNER;
               rsp_tx_in     = far_x_ff;
               rsp_ty_in     = far_y_ff;
               rsp_rvalid_in = worst_found_ff;
               rsp_rid_in    = worst_found_ff ? worst_id_ff : '0;
               rsp_ovf_in    = overflow_ff;
               near_count_in = '0;
               far_found_in  = 1'b0;
               far_key_in    = '0;
               far_id_in     = '0;
               far_x_in      = '0;
               far_y_in      = '0;
               overflow_in   = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               dist_req.start = 1'b1;
               dist_req.px    = entry_x_ff;
               dist_req.py    = entry_y_ff;
               state_in       = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (dist_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = overflow_ff;
               if (dist_rsp.far) begin
                  rsp_kind_in   = PLAN_RETREAT;
                  rsp_reason_in = REASON_ENTRY;
                  rsp_tx_in     = entry_x_ff;
                  rsp_ty_in     = entry_y_ff;
                  rsp_rvalid_in = worst_found_ff;
                  rsp_rid_in    = worst_found_ff ? worst_id_ff : '0;
               end else begin
                  rsp_kind_in   = PLAN_EXHAUSTED;
                  rsp_reason_in = REASON_AT_ENTRY;
                  rsp_tx_in     = '0;
                  rsp_ty_in     = '0;
                  rsp_rvalid_in = 1'b0;
                  rsp_rid_in    = '0;
               end
               near_count_in = '0;
               far_found_in  = 1'b0;
               far_key_in    = '0;
               far_id_in     = '0;
               far_x_in      = '0;
               far_y_in      = '0;
               overflow_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tol_ff        <= TOL_RESET;
         robot_x_ff    <= '0;
         robot_y_ff    <= '0;
         entry_x_ff    <= '0;
         entry_y_ff    <= '0;
         near_count_ff <= '0;
         far_found_ff  <= 1'b0;
         far_key_ff    <= '0;
         far_id_ff     <= '0;
         far_x_ff      <= '0;
         far_y_ff      <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tol_ff        <= tol_in;
         robot_x_ff    <= robot_x_in;
         robot_y_ff    <= robot_y_in;
         entry_x_ff    <= entry_x_in;
         entry_y_ff    <= entry_y_in;
         near_count_ff <= near_count_in;
         far_found_ff  <= far_found_in;
         far_key_ff    <= far_key_in;
         far_id_ff     <= far_id_in;
         far_x_ff      <= far_x_in;
         far_y_ff      <= far_y_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cand_key_ff    <= cand_key_in;
      cand_id_ff     <= cand_id_in;
      cand_x_ff      <= cand_x_in;
      cand_y_ff      <= cand_y_in;
      scan_idx_ff    <= scan_idx_in;
      worst_found_ff <= worst_found_in;
      worst_key_ff   <= worst_key_in;
      worst_id_ff    <= worst_id_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_reason_ff  <= rsp_reason_in;
      rsp_tx_ff      <= rsp_tx_in;
      rsp_ty_ff      <= rsp_ty_in;
      rsp_rvalid_ff  <= rsp_rvalid_in;
      rsp_rid_ff     <= rsp_rid_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_plan_kind      = rsp_kind_ff;
   assign rsp_reason_code    = rsp_reason_ff;
   assign rsp_target_x       = rsp_tx_ff;
   assign rsp_target_y       = rsp_ty_ff;
   assign rsp_retired_valid  = rsp_rvalid_ff;
   assign rsp_spent_id       = rsp_rid_ff;
   assign rsp_store_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

@@ rtl/ets_dist_unit.sv @@
// Squared-distance test against the tolerance on one shared multiplier.
`default_nettype none
module ets_dist_unit
   import ets_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dist_req_type                 dist_req,
   input  wire logic signed [COORD_BITS-1:0] robot_x,
   input  wire logic signed [COORD_BITS-1:0] robot_y,
   input  wire logic [TOL_BITS-1:0]          tol,
   output dist_rsp_type                      dist_rsp
);

   typedef enum logic [5:0] {
      DS_IDLE = 6'b000001,
      DS_CHK  = 6'b000010,
      DS_SQX  = 6'b000100,
      DS_SQY  = 6'b001000,
      DS_SQT  = 6'b010000,
      DS_CMP  = 6'b100000
   } dstate_type;

   dstate_type                 state_ff, state_in;
   logic [DIFF_BITS-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_BITS-1:0]         prod_ff, prod_in;
   logic [SUM_BITS-1:0]        sum_ff, sum_in;
   logic                       done_ff, done_in, far_ff, far_in;

   logic signed [DIFF_BITS-1:0] diff_x, diff_y;
   logic [TOL_BITS-1:0]         mul_a, mul_b;
   logic [SQ_BITS-1:0]          product;

   assign diff_x  = DIFF_BITS'(dist_req.px) - DIFF_BITS'(robot_x);
   assign diff_y  = DIFF_BITS'(dist_req.py) - DIFF_BITS'(robot_y);
   assign product = SQ_BITS'(mul_a) * SQ_BITS'(mul_b);

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      done_in  = 1'b0;
      far_in   = far_ff;
      unique case (state_ff)
         DS_IDLE: begin
            if (dist_req.start) begin
               dx_in    = diff_x[DIFF_BITS-1] ? DIFF_BITS'(-diff_x) : DIFF_BITS'(diff_x);
               dy_in    = diff_y[DIFF_BITS-1] ? DIFF_BITS'(-diff_y) : DIFF_BITS'(diff_y);
               state_in = DS_CHK;
            end
         end
         DS_CHK: begin
            if (dx_ff > DIFF_BITS'(tol) || dy_ff > DIFF_BITS'(tol)) begin
               done_in  = 1'b1;
               far_in   = 1'b1;
               state_in = DS_IDLE;
            end else begin
               state_in = DS_SQX;
            end
         end
         DS_SQX: begin
            mul_a    = dx_ff[TOL_BITS-1:0];
            mul_b    = dx_ff[TOL_BITS-1:0];
            prod_in  = product;
            state_in = DS_SQY;
         end
         DS_SQY: begin
            mul_a    = dy_ff[TOL_BITS-1:0];
            mul_b    = dy_ff[TOL_BITS-1:0];
            prod_in  = product;
            sum_in   = SUM_BITS'(prod_ff);
            state_in = DS_SQT;
         end
         DS_SQT: begin
            mul_a    = tol;
            mul_b    = tol;
            prod_in  = product;
            sum_in   = sum_ff + SUM_BITS'(prod_ff);
            state_in = DS_CMP;
         end
         DS_CMP: begin
            done_in  = 1'b1;
            far_in   = sum_ff > SUM_BITS'(prod_ff);
            state_in = DS_IDLE;
         end
         default: state_in = DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      far_ff  <= far_in;
   end

   assign dist_rsp.done = done_ff;
   assign dist_rsp.far  = far_ff;

endmodule
`default_nettype wire

@@ rtl/ets_near_store.sv @@
// Near-candidate store: rank key and id per entry, registered read.
`default_nettype none
module ets_near_store
   import ets_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_BITS-1:0]   wr_addr,
   input  wire logic [SCORE_BITS-1:0] wr_key,
   input  wire logic [ID_BITS-1:0]    wr_id,
   input  wire logic                  rd_en,
   input  wire logic [IDX_BITS-1:0]   rd_addr,
   output logic [SCORE_BITS-1:0]      rd_key,
   output logic [ID_BITS-1:0]         rd_id
);

   logic [SCORE_BITS+ID_BITS-1:0] mem [MAX_CANDIDATES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_id};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         {rd_key, rd_id} <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ dv/escape_target_selector_top_tb.sv @@
// Self-checking testbench of the escape target selector: directed rows and store floods, then random sessions.
`timescale 1ns / 1ps
module escape_target_selector_top_tb;
   import ets_pkg::*;

   localparam op_type              OP_UNUSED     = 2'd3;
   localparam int                  RANDOM_ITEMS  = 1000;
   localparam int                  SETTLE_CYCLES = 8;
   localparam logic [TOL_BITS-1:0] TOL_MAX       = '1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SCORE_BITS-1:0] score_type;
   typedef logic [ID_BITS-1:0]           ident_type;

   localparam coord_type C_MAX = 24'h7FFFFF;
   localparam coord_type C_MIN = 24'h800000;
   localparam score_type S_MAX = 32'h7FFFFFFF;
   localparam score_type S_MIN = 32'h80000000;

   typedef struct {
      op_type    op;
      coord_type px, py, ex, ey;
      score_type score;
      ident_type id;
      coord_type ox, oy;
   } cmd_type;

   typedef struct {
      logic       plan_kind;
      reason_type reason;
      coord_type  tx, ty;
      logic       retired_valid;
      ident_type  spent_id;
      logic       overflow;
   } decision_type;

   typedef struct {
      cmd_type      cmd;
      bit           fixed;
      decision_type dec;
   } row_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                start              = 1'b0;
   logic                busy;
   logic [1:0]          req_op             = '0;
   coord_type           req_pose_x         = '0;
   coord_type           req_pose_y         = '0;
   coord_type           req_entry_x        = '0;
   coord_type           req_entry_y        = '0;
   score_type           req_cand_score     = '0;
   ident_type           req_cand_id        = '0;
   coord_type           req_owner_x        = '0;
   coord_type           req_owner_y        = '0;
   logic                rsp_valid;
   logic                rsp_plan_kind;
   logic [1:0]          rsp_reason_code;
   coord_type           rsp_target_x;
   coord_type           rsp_target_y;
   logic                rsp_retired_valid;
   ident_type           rsp_spent_id;
   logic                rsp_store_overflow;
   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic [TOL_BITS-1:0] csr_data           = '0;

   // predictor state
   logic [TOL_BITS-1:0]   tol_q = TOL_RESET;
   coord_type             robot_x = '0, robot_y = '0, home_x = '0, home_y = '0;
   logic [SCORE_BITS-1:0] near_keys[$];
   ident_type             near_ids[$];
   bit                    far_valid = 1'b0;
   logic [SCORE_BITS-1:0] far_key = '0;
   ident_type             far_id = '0;
   coord_type             far_x = '0, far_y = '0;
   bit                    store_spilled = 1'b0;

   decision_type pending_decisions[$];
   int           err_count  = 0;
   int           item_count = 0;
   bit           steady     = 1'b0;

   escape_target_selector_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_pose_x         (req_pose_x),
      .req_pose_y         (req_pose_y),
      .req_entry_x        (req_entry_x),
      .req_entry_y        (req_entry_y),
      .req_cand_score     (req_cand_score),
      .req_cand_id        (req_cand_id),
      .req_owner_x        (req_owner_x),
      .req_owner_y        (req_owner_y),
      .rsp_valid          (rsp_valid),
      .rsp_plan_kind      (rsp_plan_kind),
      .rsp_reason_code    (rsp_reason_code),
      .rsp_target_x       (rsp_target_x),
      .rsp_target_y       (rsp_target_y),
      .rsp_retired_valid  (rsp_retired_valid),
      .rsp_spent_id       (rsp_spent_id),
      .rsp_store_overflow (rsp_store_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   initial begin : watchdog
      #(10_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // strictly outside the tolerance circle round the robot
   function automatic bit beyond_tolerance(coord_type px, coord_type py);
      longint dx, dy, tol;
      dx  = longint'(px) - longint'(robot_x);
      dy  = longint'(py) - longint'(robot_y);
      tol = longint'(tol_q);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > tol || dy > tol) return 1'b1;
      return (dx * dx + dy * dy) > (tol * tol);
   endfunction

   function automatic bit outranks(logic [SCORE_BITS-1:0] ka, ident_type ia,
                                   logic [SCORE_BITS-1:0] kb, ident_type ib);
      if (ka != kb) return ka > kb;
      return ia < ib;
   endfunction

   function automatic void clear_candidates();
      near_keys.delete();
      near_ids.delete();
      far_valid     = 1'b0;
      far_key       = '0;
      far_id        = '0;
      far_x         = '0;
      far_y         = '0;
      store_spilled = 1'b0;
   endfunction

   function automatic void predict_decision(cmd_type c, output bit has,
                                            output decision_type d);
      logic [SCORE_BITS-1:0] key;
      logic [SCORE_BITS-1:0] wk;
      ident_type             wi;
      bit                    found;
      has   = 1'b0;
      d     = '{default: '0};
      found = 1'b0;
      wk    = '0;
      wi    = '0;
      case (c.op)
         OP_START: begin
            robot_x = c.px;
            robot_y = c.py;
            home_x  = c.ex;
            home_y  = c.ey;
            clear_candidates();
         end
         OP_CAND: begin
            key = c.score ^ SCORE_FLIP;
            if (beyond_tolerance(c.ox, c.oy)) begin
               if (!far_valid || outranks(key, c.id, far_key, far_id)) begin
                  far_valid = 1'b1;
                  far_key   = key;
                  far_id    = c.id;
                  far_x     = c.ox;
                  far_y     = c.oy;
               end
            end else if (near_keys.size() < MAX_CANDIDATES) begin
               near_keys.push_back(key);
               near_ids.push_back(c.id);
            end else begin
               store_spilled = 1'b1;
            end
         end
         OP_FINISH: begin
            // worst-ranked near candidate that still ranks above the far best
            foreach (near_keys[i]) begin
               if (!far_valid || outranks(near_keys[i], near_ids[i], far_key, far_id)) begin
                  if (!found || outranks(wk, wi, near_keys[i], near_ids[i])) begin
                     found = 1'b1;
                     wk    = near_keys[i];
                     wi    = near_ids[i];
                  end
               end
            end
            if (far_valid) begin
               d.plan_kind     = PLAN_RETREAT;
               d.reason        = REASON_OWNER;
               d.tx            = far_x;
               d.ty            = far_y;
               d.retired_valid = found;
               d.spent_id      = found ? wi : '0;
            end else if (beyond_tolerance(home_x, home_y)) begin
               d.plan_kind     = PLAN_RETREAT;
               d.reason        = REASON_ENTRY;
               d.tx            = home_x;
               d.ty            = home_y;
               d.retired_valid = found;
               d.spent_id      = found ? wi : '0;
            end else begin
               d.plan_kind = PLAN_EXHAUSTED;
               d.reason    = REASON_AT_ENTRY;
            end
            d.overflow = store_spilled;
            has        = 1'b1;
            clear_candidates();
         end
         default: ;
      endcase
   endfunction

   function automatic cmd_type start_cmd(coord_type px, coord_type py,
                                         coord_type ex, coord_type ey);
      cmd_type c;
      c    = '{default: '0};
      c.op = OP_START;
      c.px = px;
      c.py = py;
      c.ex = ex;
      c.ey = ey;
      return c;
   endfunction

   function automatic cmd_type cand_cmd(score_type score, ident_type id,
                                        coord_type ox, coord_type oy);
      cmd_type c;
      c       = '{default: '0};
      c.op    = OP_CAND;
      c.score = score;
      c.id    = id;
      c.ox    = ox;
      c.oy    = oy;
      return c;
   endfunction

   function automatic cmd_type bare_cmd(op_type op);
      cmd_type c;
      c    = '{default: '0};
      c.op = op;
      return c;
   endfunction

   function automatic cmd_type noise_cmd();
      cmd_type c;
      c.op    = op_type'($urandom_range(3));
      c.px    = coord_type'($urandom);
      c.py    = coord_type'($urandom);
      c.ex    = coord_type'($urandom);
      c.ey    = coord_type'($urandom);
      c.score = score_type'($urandom);
      c.id    = ident_type'($urandom);
      c.ox    = coord_type'($urandom);
      c.oy    = coord_type'($urandom);
      return c;
   endfunction

   function automatic decision_type verdict(logic kind, reason_type r,
                                            coord_type tx, coord_type ty,
                                            logic rv, ident_type rid, logic ovf);
      decision_type d;
      d.plan_kind     = kind;
      d.reason        = r;
      d.tx            = tx;
      d.ty            = ty;
      d.retired_valid = rv;
      d.spent_id      = rid;
      d.overflow      = ovf;
      return d;
   endfunction

   function automatic row_type plain(cmd_type c);
      row_type r;
      r.cmd   = c;
      r.fixed = 1'b0;
      r.dec   = '{default: '0};
      return r;
   endfunction

   function automatic row_type pinned(cmd_type c, decision_type d);
      row_type r;
      r.cmd   = c;
      r.fixed = 1'b1;
      r.dec   = d;
      return r;
   endfunction

   function automatic score_type rand_score();
      case ($urandom_range(3))
         0, 1:    return score_type'($urandom_range(7)) - 3;
         2:       return score_type'($urandom);
         default: begin
            case ($urandom_range(3))
               0:       return S_MAX;
               1:       return S_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic ident_type rand_id();
      if ($urandom_range(1) == 0) return ident_type'($urandom_range(7));
      return ident_type'($urandom_range(65535));
   endfunction

   // a point close to base, within one or two tolerance spans round base, or anywhere at all
   function automatic coord_type around(coord_type base);
      longint span, off;
      span = longint'(tol_q) + 2;
      off  = 0;
      case ($urandom_range(3))
         0:       return coord_type'($urandom);
         1:       off = longint'($urandom_range(int'(2 * span))) - span;
         2:       off = longint'($urandom_range(int'(4 * span))) - 2 * span;
         default: off = longint'($urandom_range(4)) - 2;
      endcase
      return coord_type'(longint'(base) + off);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      err_count++;
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic issue(cmd_type c, bit fixed, decision_type fixed_dec);
      int           gap;
      bit           has;
      decision_type d;
      gap = (!steady && $urandom_range(99) < 33) ? $urandom_range(2, 1) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_op         <= c.op;
      req_pose_x     <= c.px;
      req_pose_y     <= c.py;
      req_entry_x    <= c.ex;
      req_entry_y    <= c.ey;
      req_cand_score <= c.score;
      req_cand_id    <= c.id;
      req_owner_x    <= c.ox;
      req_owner_y    <= c.oy;
      do @(posedge clock); while (busy);
      predict_decision(c, has, d);
      if (has) pending_decisions.push_back(fixed ? fixed_dec : d);
      if (c.op != OP_UNUSED) item_count++;
   endtask

   task automatic send(cmd_type c);
      issue(c, 1'b0, '{default: '0});
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tol_q = value;
   endtask

   task automatic near_flood(int n);
      send(start_cmd('0, '0, C_MAX, '0));
      repeat (n)
         send(cand_cmd(rand_score(), rand_id(), coord_type'($urandom_range(1000)),
                       -coord_type'($urandom_range(1000))));
      send(cand_cmd(rand_score(), rand_id(), 5000, 5000));
      send(bare_cmd(OP_FINISH));
   endtask

   task automatic random_session();
      int        n;
      coord_type rx, ry;
      if ($urandom_range(9) == 0) send(noise_cmd());
      rx = ($urandom_range(1) == 0) ? coord_type'($urandom)
                                    : coord_type'($urandom_range(8191)) - 4096;
      ry = ($urandom_range(1) == 0) ? coord_type'($urandom)
                                    : coord_type'($urandom_range(8191)) - 4096;
      send(start_cmd(rx, ry, around(rx), around(ry)));
      case ($urandom_range(19))
         0:       n = $urandom_range(72, 60);
         1, 2:    n = $urandom_range(40, 9);
         default: n = $urandom_range(8);
      endcase
      repeat (n) begin
         if ($urandom_range(39) == 0) send(bare_cmd(OP_UNUSED));
         send(cand_cmd(rand_score(), rand_id(), around(rx), around(ry)));
      end
      send(bare_cmd(OP_FINISH));
   endtask

   always @(posedge clock) begin : result_check
      decision_type want;
      if (!reset && rsp_valid) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_plan_kind !== want.plan_kind)
               report_mismatch("plan_kind", rsp_plan_kind, want.plan_kind);
            if (rsp_reason_code !== want.reason)
               report_mismatch("reason_code", rsp_reason_code, want.reason);
            if (rsp_target_x !== want.tx)
               report_mismatch("target_x", rsp_target_x, want.tx);
            if (rsp_target_y !== want.ty)
               report_mismatch("target_y", rsp_target_y, want.ty);
            if (rsp_retired_valid !== want.retired_valid)
               report_mismatch("retired_valid", rsp_retired_valid, want.retired_valid);
            if (rsp_spent_id !== want.spent_id)
               report_mismatch("spent_id", rsp_spent_id, want.spent_id);
            if (rsp_store_overflow !== want.overflow)
               report_mismatch("store_overflow", rsp_store_overflow, want.overflow);
         end
      end
   end

   initial begin : stimulus
      row_type      rows[$];
      decision_type none;
      int           base;
      none = verdict(PLAN_EXHAUSTED, REASON_AT_ENTRY, '0, '0, 1'b0, '0, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // finish straight after reset, on reset poses
      rows.push_back(pinned(bare_cmd(OP_FINISH), none));
      rows.push_back(plain(bare_cmd(OP_UNUSED)));
      // empty set, entry at the far corner
      rows.push_back(plain(start_cmd('0, '0, C_MAX, C_MIN)));
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_ENTRY, C_MAX, C_MIN, 1'b0, '0, 1'b0)));
      // extreme poses and scores; near candidate ranks below the far one
      rows.push_back(plain(start_cmd(C_MIN, C_MAX, C_MAX, C_MIN)));
      rows.push_back(plain(cand_cmd(S_MAX, '0, C_MAX, C_MIN)));
      rows.push_back(plain(cand_cmd(S_MIN, '1, C_MIN, C_MAX)));
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_OWNER, C_MAX, C_MIN, 1'b0, '0, 1'b0)));
      // retired is the near candidate ranked just above the far best
      rows.push_back(plain(start_cmd('0, '0, '0, '0)));
      rows.push_back(plain(cand_cmd(100, 5, 100, 100)));
      rows.push_back(plain(cand_cmd(50, 7, 4096, 0)));
      rows.push_back(plain(cand_cmd(100, 3, 0, 0)));
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_OWNER, 4096, 0, 1'b1, 5, 1'b0)));
      // identical score and id: first far kept, equal near not retired
      rows.push_back(plain(start_cmd('0, '0, '0, '0)));
      rows.push_back(plain(cand_cmd(10, 9, 5000, 0)));
      rows.push_back(plain(cand_cmd(10, 9, 6000, 0)));
      rows.push_back(plain(cand_cmd(10, 9, 0, 0)));
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_OWNER, 5000, 0, 1'b0, '0, 1'b0)));
      // tolerance boundary, on axis and on the diagonal
      rows.push_back(plain(start_cmd('0, '0, '0, '0)));
      rows.push_back(plain(cand_cmd(1, 1, 2048, 0)));
      rows.push_back(plain(cand_cmd(2, 2, 1448, 1448)));
      rows.push_back(pinned(bare_cmd(OP_FINISH), none));
      rows.push_back(plain(cand_cmd(3, 3, -1449, 1449)));
      rows.push_back(plain(cand_cmd(4, 4, 0, -2049)));
      rows.push_back(plain(bare_cmd(OP_FINISH)));
      // entry retreat retires the worst-ranked candidate
      rows.push_back(plain(start_cmd('0, '0, 10000, 10000)));
      rows.push_back(plain(cand_cmd(-5, 2, 10, 10)));
      rows.push_back(plain(cand_cmd(7, 1, -10, 0)));
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_ENTRY, 10000, 10000, 1'b1, 2, 1'b0)));
      // finish with no start and an empty set
      rows.push_back(pinned(bare_cmd(OP_FINISH),
                            verdict(PLAN_RETREAT, REASON_ENTRY, 10000, 10000, 1'b0, '0, 1'b0)));

      foreach (rows[i]) issue(rows[i].cmd, rows[i].fixed, rows[i].dec);

      // store exactly full, then one over
      near_flood(MAX_CANDIDATES);
      near_flood(MAX_CANDIDATES + 1);

      write_tolerance('0);
      random_session();
      write_tolerance(TOL_MAX);
      random_session();
      random_session();

      base = item_count;
      while (item_count - base < RANDOM_ITEMS) begin
         steady = (item_count - base >= 400) && (item_count - base < 650);
         case ($urandom_range(5))
            0:       write_tolerance('0);
            1:       write_tolerance(TOL_MAX);
            2:       write_tolerance(TOL_RESET);
            3:       write_tolerance($urandom_range(4096, 1));
            4:       write_tolerance($urandom_range(1 << 20, 4097));
            default: write_tolerance($urandom);
         endcase
         repeat ($urandom_range(8, 3)) random_session();
      end

      start <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (4 * MAX_CANDIDATES) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
